/* design/bfm_pkg.sv */
// Shared types, constants and helper functions for the box-filter mip chain.
// Used by the front, queue, level engine and top modules; it depends on nothing else.
package bfm_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_LEVELS = 13;

  localparam int DIM_W  = 13;  // configured dimension, 1..4096
  localparam int POS_W  = 12;  // column or row within a level
  localparam int LVL_W  = 4;   // level number and level count
  localparam int PIX_W  = 32;  // four 8-bit channels
  localparam int SUM_W  = 36;  // four 9-bit channel sums
  localparam int ROW_BUF_DEPTH = 4096;
  localparam int ADDR_W = 2;   // configuration register index

  // Configuration register indexes.
  localparam logic [ADDR_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [ADDR_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  // Geometry of the pyramid, produced by the front and read by the back.
  typedef struct packed {
    logic [DIM_W-1:0]                  img_w;
    logic [DIM_W-1:0]                  img_h;
    logic [LVL_W-1:0]                  num_levels;
    logic [MAX_LEVELS-1:0][POS_W-1:0]  off;
  } geom_t;

  // One queued level-0 pixel and whether it closes the image.
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             final_pix;
  } q_item_t;

  // Dimension of a level: halved per level, never below one.
  function automatic logic [DIM_W-1:0] level_dim(input logic [DIM_W-1:0] v,
                                                 input logic [LVL_W-1:0] lv);
    logic [DIM_W-1:0] s;
    s = v >> lv;
    return (s == '0) ? DIM_W'(1) : s;
  endfunction

  // Spread four 8-bit channels into 9-bit lanes.
  function automatic logic [SUM_W-1:0] widen(input logic [PIX_W-1:0] p);
    return {1'b0, p[31:24], 1'b0, p[23:16], 1'b0, p[15:8], 1'b0, p[7:0]};
  endfunction

  // Rounded average of the four pixels behind two pair sums, per channel.
  function automatic logic [PIX_W-1:0] avg4(input logic [SUM_W-1:0] a,
                                            input logic [SUM_W-1:0] b);
    logic [PIX_W-1:0] o;
    logic [10:0]      s;
    o = '0;
    for (int k = 0; k < 4; k++) begin
      s = 11'(a[9*k +: 9]) + 11'(b[9*k +: 9]) + 11'd2;
      o[8*k +: 8] = s[9:2];
    end
    return o;
  endfunction

endpackage

/* design/bfm_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; used for the row buffer of horizontal pair sums.
module bfm_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/bfm_fifo.sv */
// Two-entry queue between the pixel front end and the level engine.
// Depends on bfm_pkg for the queued item type.
module bfm_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  bfm_pkg::q_item_t push_item,
  output logic             not_full,
  input  logic             pop,
  output logic             not_empty,
  output bfm_pkg::q_item_t head
);

  bfm_pkg::q_item_t slot_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  assign not_full  = (cnt_r != 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = slot_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* design/bfm_front.sv */
// Front end: configuration registers, geometry sweep, pixel intake and the
// level-0 position that marks the last pixel of an image. Uses bfm_pkg.
module bfm_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [bfm_pkg::ADDR_W-1:0]   cfg_addr,
  input  logic [bfm_pkg::DIM_W-1:0]    cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bfm_pkg::PIX_W-1:0]    in_pixel_rgba,
  output logic                         q_push,
  output bfm_pkg::q_item_t             q_item,
  input  logic                         q_not_full,
  output bfm_pkg::geom_t               geom,
  output logic                         clr
);

  logic [bfm_pkg::DIM_W-1:0]  w_r, w_nxt, h_r, h_nxt;
  logic                       busy_r, busy_nxt;
  logic [bfm_pkg::LVL_W-1:0]  sw_lv_r, sw_lv_nxt;
  logic [bfm_pkg::POS_W-1:0]  acc_r, acc_nxt;
  logic [bfm_pkg::LVL_W-1:0]  num_r, num_nxt;
  logic [bfm_pkg::MAX_LEVELS-1:0][bfm_pkg::POS_W-1:0] off_r, off_nxt;
  logic [bfm_pkg::POS_W-1:0]  c0_r, c0_nxt, r0_r, r0_nxt;
  logic                       wr_ok;
  logic [bfm_pkg::DIM_W-1:0]  clamp_hi;
  logic [bfm_pkg::DIM_W-1:0]  clamped;
  logic                       accept;
  logic                       final_pix;
  logic [bfm_pkg::DIM_W-1:0]  pw, ph, cw;

  // Each register saturates at its own maximum.
  assign clamp_hi = (cfg_addr == bfm_pkg::CFG_IMAGE_HEIGHT) ?
                    bfm_pkg::DIM_W'(bfm_pkg::MAX_HEIGHT) : bfm_pkg::DIM_W'(bfm_pkg::MAX_WIDTH);

  // A write of zero acts as one; larger than the maximum saturates.
  always_comb begin
    if (cfg_wdata == '0) begin
      clamped = bfm_pkg::DIM_W'(1);
    end else if (cfg_wdata > clamp_hi) begin
      clamped = clamp_hi;
    end else begin
      clamped = cfg_wdata;
    end
  end

  assign wr_ok = cfg_we &&
                 (cfg_addr == bfm_pkg::CFG_IMAGE_WIDTH || cfg_addr == bfm_pkg::CFG_IMAGE_HEIGHT);
  assign clr   = wr_ok;

  // Pixel intake and last-pixel detection on level 0.
  assign in_ready  = !busy_r && q_not_full;
  assign accept    = in_valid && in_ready;
  assign final_pix = ({1'b0, c0_r} + 13'd1 >= w_r) && ({1'b0, r0_r} + 13'd1 >= h_r);
  assign q_push    = accept;
  assign q_item    = '{pix: in_pixel_rgba, final_pix: final_pix};

  assign geom = '{img_w: w_r, img_h: h_r, num_levels: num_r, off: off_r};

  // Geometry sweep: one level per cycle for levels one to twelve.
  assign pw = bfm_pkg::level_dim(w_r, sw_lv_r - 4'd1);
  assign ph = bfm_pkg::level_dim(h_r, sw_lv_r - 4'd1);
  assign cw = bfm_pkg::level_dim(w_r, sw_lv_r);

  always_comb begin
    w_nxt     = w_r;
    h_nxt     = h_r;
    busy_nxt  = busy_r;
    sw_lv_nxt = sw_lv_r;
    acc_nxt   = acc_r;
    num_nxt   = num_r;
    off_nxt   = off_r;
    c0_nxt    = c0_r;
    r0_nxt    = r0_r;
    if (wr_ok) begin
      if (cfg_addr == bfm_pkg::CFG_IMAGE_WIDTH) begin
        w_nxt = clamped;
      end else begin
        h_nxt = clamped;
      end
      busy_nxt  = 1'b1;
      sw_lv_nxt = 4'd1;
      acc_nxt   = '0;
      num_nxt   = 4'd1;
      c0_nxt    = '0;
      r0_nxt    = '0;
    end else if (busy_r) begin
      if (pw > 13'd1 || ph > 13'd1) begin
        num_nxt = sw_lv_r + 4'd1;
      end
      off_nxt[sw_lv_r] = acc_r;
      acc_nxt = acc_r + cw[bfm_pkg::POS_W-1:0];
      if (sw_lv_r == 4'(bfm_pkg::MAX_LEVELS - 1)) begin
        busy_nxt = 1'b0;
      end else begin
        sw_lv_nxt = sw_lv_r + 4'd1;
      end
    end else if (accept) begin
      if ({1'b0, c0_r} + 13'd1 >= w_r) begin
        c0_nxt = '0;
        r0_nxt = ({1'b0, r0_r} + 13'd1 >= h_r) ? '0 : r0_r + 12'd1;
      end else begin
        c0_nxt = c0_r + 12'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r     <= 13'd1;
      h_r     <= 13'd1;
      busy_r  <= 1'b0;
      sw_lv_r <= 4'd1;
      acc_r   <= '0;
      num_r   <= 4'd1;
      c0_r    <= '0;
      r0_r    <= '0;
    end else begin
      w_r     <= w_nxt;
      h_r     <= h_nxt;
      busy_r  <= busy_nxt;
      sw_lv_r <= sw_lv_nxt;
      acc_r   <= acc_nxt;
      num_r   <= num_nxt;
      c0_r    <= c0_nxt;
      r0_r    <= r0_nxt;
    end
  end

  // Offsets are only read for levels inside the pyramid, after a sweep.
  always_ff @(posedge clk) begin
    off_r <= off_nxt;
  end

endmodule

/* design/bfm_back.sv */
// Level engine: walks one queued pixel up the pyramid, emitting each level
// then averaging up, using the row buffer RAM. Uses bfm_pkg and bfm_ram.
module bfm_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bfm_pkg::geom_t              geom,
  input  logic                        clr,
  input  logic                        q_not_empty,
  input  bfm_pkg::q_item_t            q_head,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bfm_pkg::LVL_W-1:0]   out_level,
  output logic [bfm_pkg::POS_W-1:0]   out_col,
  output logic [bfm_pkg::POS_W-1:0]   out_row,
  output logic [bfm_pkg::PIX_W-1:0]   out_rgba,
  output logic                        out_last_of_item,
  output logic                        out_pyramid_done,
  output logic [bfm_pkg::LVL_W-1:0]   out_level_count
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EMIT = 2'd1;
  localparam logic [1:0] ST_AVG  = 2'd2;

  logic [1:0]                 st_r, st_nxt;
  logic [bfm_pkg::LVL_W-1:0]  lv_r, lv_nxt;
  logic [bfm_pkg::PIX_W-1:0]  pix_r, pix_nxt;
  logic                       fin_r, fin_nxt;
  logic [bfm_pkg::SUM_W-1:0]  hp_r, hp_nxt;
  logic                       use_ram_r, use_ram_nxt;
  logic [bfm_pkg::POS_W-1:0]  col_r [bfm_pkg::MAX_LEVELS];
  logic [bfm_pkg::POS_W-1:0]  row_r [bfm_pkg::MAX_LEVELS];
  logic [bfm_pkg::PIX_W-1:0]  held_r [bfm_pkg::MAX_LEVELS-1];
  logic                       ov_r, ov_nxt;

  logic                       out_free, fire;
  logic [bfm_pkg::POS_W-1:0]  c, r;
  logic [bfm_pkg::DIM_W-1:0]  sw, sh;
  logic                       top, brk, hold_left, store_row;
  logic [bfm_pkg::POS_W-1:0]  idx;
  logic [bfm_pkg::SUM_W-1:0]  hp;
  logic                       ram_re;
  logic [bfm_pkg::SUM_W-1:0]  ram_rdata;
  logic [bfm_pkg::SUM_W-1:0]  above;

  // Row buffer of horizontal pair sums, one row per level above zero.
  bfm_ram #(.WIDTH(bfm_pkg::SUM_W), .DEPTH(bfm_pkg::ROW_BUF_DEPTH)) u_rowbuf (
    .clk   (clk),
    .we    (fire && store_row),
    .waddr (idx),
    .wdata (hp),
    .re    (ram_re),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  assign out_free  = !ov_r || out_ready;
  assign out_valid = ov_r;
  assign q_pop     = (st_r == ST_IDLE) && q_not_empty;
  assign fire      = (st_r == ST_EMIT) && out_free;

  // Classify the current level: emit only, or continue to the next one.
  always_comb begin
    c         = col_r[lv_r];
    r         = row_r[lv_r];
    sw        = bfm_pkg::level_dim(geom.img_w, lv_r);
    sh        = bfm_pkg::level_dim(geom.img_h, lv_r);
    top       = ({1'b0, lv_r} + 5'd1 >= {1'b0, geom.num_levels});
    hold_left = !top && (sw != 13'd1) && !c[0];
    store_row = 1'b0;
    brk       = 1'b1;
    idx       = '0;
    hp        = bfm_pkg::widen(pix_r) << 1;
    if (!top) begin
      idx = geom.off[lv_r + 4'd1] + {1'b0, c[bfm_pkg::POS_W-1:1]};
      if (sw != 13'd1) begin
        hp = bfm_pkg::widen(held_r[lv_r]) + bfm_pkg::widen(pix_r);
      end
      if (!hold_left) begin
        if (sh != 13'd1 && !r[0]) begin
          store_row = ({1'b0, r} + 13'd1 < sh);
        end else begin
          brk = 1'b0;
        end
      end
    end
    ram_re = fire && !brk && (sh != 13'd1);
  end

  assign above = use_ram_r ? ram_rdata : hp_r;

  // Sequencer: pop, emit a level, average into the next level.
  always_comb begin
    st_nxt      = st_r;
    lv_nxt      = lv_r;
    pix_nxt     = pix_r;
    fin_nxt     = fin_r;
    hp_nxt      = hp_r;
    use_ram_nxt = use_ram_r;
    ov_nxt      = ov_r && !out_ready;
    case (st_r)
      ST_IDLE: begin
        if (q_not_empty) begin
          pix_nxt = q_head.pix;
          fin_nxt = q_head.final_pix;
          lv_nxt  = '0;
          st_nxt  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (fire) begin
          ov_nxt      = 1'b1;
          hp_nxt      = hp;
          use_ram_nxt = (sh != 13'd1);
          st_nxt      = brk ? ST_IDLE : ST_AVG;
        end
      end
      ST_AVG: begin
        pix_nxt = bfm_pkg::avg4(above, hp_r);
        lv_nxt  = lv_r + 4'd1;
        st_nxt  = ST_EMIT;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lv_r      <= lv_nxt;
    pix_r     <= pix_nxt;
    fin_r     <= fin_nxt;
    hp_r      <= hp_nxt;
    use_ram_r <= use_ram_nxt;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_level        <= lv_r;
      out_col          <= c;
      out_row          <= r;
      out_rgba         <= pix_r;
      out_last_of_item <= brk;
      out_pyramid_done <= brk && fin_r;
      out_level_count  <= geom.num_levels;
    end
  end

  // Left pixel of each horizontal pair, per source level.
  always_ff @(posedge clk) begin
    if (fire && hold_left) begin
      held_r[lv_r] <= pix_r;
    end
  end

  // Per-level position counters; cleared on reset, reconfiguration and the
  // last pixel of an image.
  always_ff @(posedge clk) begin
    if (!rst_n || clr || (fire && brk && fin_r)) begin
      for (int i = 0; i < bfm_pkg::MAX_LEVELS; i++) begin
        col_r[i] <= '0;
        row_r[i] <= '0;
      end
    end else if (fire) begin
      if ({1'b0, c} + 13'd1 >= sw) begin
        col_r[lv_r] <= '0;
        row_r[lv_r] <= ({1'b0, r} + 13'd1 >= sh) ? '0 : r + 12'd1;
      end else begin
        col_r[lv_r] <= c + 12'd1;
      end
    end
  end

endmodule

/* design/box_filter_mip_chain_unit.sv */
// Top level of the 2x2 box-filter mipmap chain generator.
// Depends on bfm_pkg, bfm_front, bfm_fifo and bfm_back.
//
// Usage: write image_width (index 0) and image_height (index 1) through the
// cfg_ port while idle; each write starts a geometry sweep during which
// in_ready is low, and restarts the image at pixel zero. Then stream
// level-0 RGBA8 pixels in raster order on the in_ valid/ready channel.
// Every pixel yields its level-0 result plus one result for every higher
// level block it completes, each tagged with level, column and row, lowest
// level first, on the out_ valid/ready channel. out_last_of_item marks the
// last result of a pixel and out_pyramid_done the last of the image.
// The level-0 result passes through the queue, the engine's pixel register
// and the result register before out_valid rises. The engine pops a pixel
// only while idle, emits its level-0 result, then passes an averaging and
// an emit state for each higher level it reaches before the next pop.
// A two-entry queue separates intake from the engine.
// Reset restores a 1x1 image with one level. When the receiver stalls, the
// result register holds, the engine waits, the queue fills and in_ready
// drops; no result is lost.
module box_filter_mip_chain_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bfm_pkg::ADDR_W-1:0]  cfg_addr,
  input  logic [bfm_pkg::DIM_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bfm_pkg::PIX_W-1:0]   in_pixel_rgba,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bfm_pkg::LVL_W-1:0]   out_level,
  output logic [bfm_pkg::POS_W-1:0]   out_col,
  output logic [bfm_pkg::POS_W-1:0]   out_row,
  output logic [bfm_pkg::PIX_W-1:0]   out_rgba,
  output logic                        out_last_of_item,
  output logic                        out_pyramid_done,
  output logic [bfm_pkg::LVL_W-1:0]   out_level_count
);

  logic             q_push, q_not_full, q_pop, q_not_empty, clr;
  bfm_pkg::q_item_t q_item, q_head;
  bfm_pkg::geom_t   geom;

  // Intake, configuration and geometry.
  bfm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_rgba (in_pixel_rgba),
    .q_push        (q_push),
    .q_item        (q_item),
    .q_not_full    (q_not_full),
    .geom          (geom),
    .clr           (clr)
  );

  // Queue between intake and the level engine.
  bfm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Level engine and result register.
  bfm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .geom             (geom),
    .clr              (clr),
    .q_not_empty      (q_not_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_level        (out_level),
    .out_col          (out_col),
    .out_row          (out_row),
    .out_rgba         (out_rgba),
    .out_last_of_item (out_last_of_item),
    .out_pyramid_done (out_pyramid_done),
    .out_level_count  (out_level_count)
  );

endmodule

/* bench/tb_box_filter_mip_chain_unit.sv */
// Self-checking testbench for box_filter_mip_chain_unit: a directed table,
// extreme sizes and random phases, checked against a behavioral pyramid predictor.
// Depends on bfm_pkg and the block's RTL.
module tb_box_filter_mip_chain_unit;

  localparam int MAX_WIDTH  = bfm_pkg::MAX_WIDTH;
  localparam int MAX_HEIGHT = bfm_pkg::MAX_HEIGHT;
  localparam int MAX_LEVELS = bfm_pkg::MAX_LEVELS;
  localparam int DIM_W      = bfm_pkg::DIM_W;
  localparam int POS_W      = bfm_pkg::POS_W;
  localparam int LVL_W      = bfm_pkg::LVL_W;
  localparam int PIX_W      = bfm_pkg::PIX_W;
  localparam int SUM_W      = bfm_pkg::SUM_W;
  localparam int ADDR_W     = bfm_pkg::ADDR_W;
  localparam logic [ADDR_W-1:0] CFG_IMAGE_WIDTH  = bfm_pkg::CFG_IMAGE_WIDTH;
  localparam logic [ADDR_W-1:0] CFG_IMAGE_HEIGHT = bfm_pkg::CFG_IMAGE_HEIGHT;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int RB_DEPTH = MAX_WIDTH + MAX_LEVELS;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [PIX_W-1:0] rgba;
    logic             last_of_item;
    logic             pyramid_done;
    logic [LVL_W-1:0] level_count;
  } mip_result_t;

  typedef struct {
    bit               is_cfg;
    logic [ADDR_W-1:0] addr;
    logic [DIM_W-1:0] data;
    logic [PIX_W-1:0] pix;
    bit               typed;
    mip_result_t      want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [ADDR_W-1:0]   cfg_addr;
  logic [DIM_W-1:0]    cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic [PIX_W-1:0]    in_pixel_rgba;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [LVL_W-1:0]    out_level;
  logic [POS_W-1:0]    out_col;
  logic [POS_W-1:0]    out_row;
  logic [PIX_W-1:0]    out_rgba;
  logic                out_last_of_item;
  logic                out_pyramid_done;
  logic [LVL_W-1:0]    out_level_count;

  box_filter_mip_chain_unit DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: geometry, configuration and per-level buffers.
  int unsigned img_w, img_h, n_levels;
  int unsigned lvl_w [MAX_LEVELS];
  int unsigned lvl_h [MAX_LEVELS];
  int unsigned lvl_off [MAX_LEVELS];
  int unsigned col_cnt [MAX_LEVELS];
  int unsigned row_cnt [MAX_LEVELS];
  logic [SUM_W-1:0] pair_rows [RB_DEPTH];
  logic [PIX_W-1:0] left_pix [MAX_LEVELS];

  mip_result_t pending_results[$];
  int  mismatches = 0;
  int  quiet_cycles = 0;
  bit  no_idle = 0;
  bit  drained_once = 0;
  int  out_stall = 0;
  stim_row_t table_rows[$];

  // Recompute the level sizes and restart every position counter.
  function automatic void rebuild_levels();
    int unsigned sw, sh, off, lv;
    sw = img_w; sh = img_h; off = 0; lv = 1;
    lvl_w[0] = sw; lvl_h[0] = sh; lvl_off[0] = 0;
    while ((sw > 1 || sh > 1) && lv < MAX_LEVELS) begin
      sw = (sw > 1) ? sw / 2 : 1;
      sh = (sh > 1) ? sh / 2 : 1;
      lvl_w[lv] = sw; lvl_h[lv] = sh; lvl_off[lv] = off;
      off += sw;
      lv++;
    end
    n_levels = lv;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      col_cnt[i] = 0;
      row_cnt[i] = 0;
    end
  endfunction

  function automatic logic [SUM_W-1:0] spread_lanes(input logic [PIX_W-1:0] p);
    logic [SUM_W-1:0] s;
    s = '0;
    for (int k = 0; k < 4; k++) s[9*k +: 9] = {1'b0, p[8*k +: 8]};
    return s;
  endfunction

  // Work out every result that one level-0 pixel causes and queue them.
  function automatic void predict_pixel(input logic [PIX_W-1:0] p_in, input bit typed,
                                        input mip_result_t want);
    mip_result_t seq [MAX_LEVELS];
    logic [PIX_W-1:0] p;
    logic [SUM_W-1:0] hp, above;
    logic [10:0] s;
    int unsigned lv, c, r, sw, sh, idx, n;
    bit fin;
    fin = (col_cnt[0] + 1 >= lvl_w[0]) && (row_cnt[0] + 1 >= lvl_h[0]);
    p = p_in; lv = 0; n = 0;
    while (1) begin
      c = col_cnt[lv]; r = row_cnt[lv]; sw = lvl_w[lv]; sh = lvl_h[lv];
      col_cnt[lv] = c + 1;
      if (c + 1 >= sw) begin
        col_cnt[lv] = 0;
        row_cnt[lv] = (r + 1 >= sh) ? 0 : r + 1;
      end
      seq[n] = '{level: lv[LVL_W-1:0], col: c[POS_W-1:0], row: r[POS_W-1:0],
                 rgba: p, last_of_item: 1'b0, pyramid_done: 1'b0,
                 level_count: n_levels[LVL_W-1:0]};
      n++;
      if (lv + 1 >= n_levels) break;
      // Horizontal pair: a single column is doubled.
      if (sw == 1) hp = spread_lanes(p) << 1;
      else if (c[0] == 1'b0) begin
        left_pix[lv] = p;
        break;
      end else hp = spread_lanes(left_pix[lv]) + spread_lanes(p);
      // Vertical pair: even rows park their sum, odd rows consume it.
      idx = lvl_off[lv + 1] + (c >> 1);
      if (sh == 1) above = hp;
      else if (r[0] == 1'b0) begin
        if (r + 1 < sh && idx < RB_DEPTH) pair_rows[idx] = hp;
        break;
      end else above = (idx < RB_DEPTH) ? pair_rows[idx] : '0;
      for (int k = 0; k < 4; k++) begin
        s = 11'(above[9*k +: 9]) + 11'(hp[9*k +: 9]) + 11'd2;
        p[8*k +: 8] = s[9:2];
      end
      lv++;
    end
    seq[n-1].last_of_item = 1'b1;
    if (fin) begin
      seq[n-1].pyramid_done = 1'b1;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        col_cnt[i] = 0;
        row_cnt[i] = 0;
      end
    end
    if (typed && n == 1) seq[0] = want;
    for (int i = 0; i < n; i++) pending_results.insert(pending_results.size(), seq[i]);
  endfunction

  // Write one register once the block has drained.
  task automatic cfg_write(input logic [ADDR_W-1:0] a, input logic [DIM_W-1:0] d);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1; cfg_addr <= a; cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (a == CFG_IMAGE_WIDTH)
      img_w = (d == 0) ? 1 : (d > MAX_WIDTH) ? MAX_WIDTH : d;
    else
      img_h = (d == 0) ? 1 : (d > MAX_HEIGHT) ? MAX_HEIGHT : d;
    rebuild_levels();
  endtask

  // Offer one pixel, with an optional gap first, and wait for its transaction.
  task automatic send_pixel(input logic [PIX_W-1:0] p, input bit typed,
                            input mip_result_t want);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_rgba <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pixel(p, typed, want);
  endtask

  function automatic void add_row(input bit is_cfg, input logic [ADDR_W-1:0] a,
                                  input logic [DIM_W-1:0] d, input logic [PIX_W-1:0] p,
                                  input bit typed);
    stim_row_t row;
    row.is_cfg = is_cfg; row.addr = a; row.data = d; row.pix = p; row.typed = typed;
    // A 1x1 image passes every pixel straight through as its own pyramid.
    row.want = '{level: '0, col: '0, row: '0, rgba: p, last_of_item: 1'b1,
                 pyramid_done: 1'b1, level_count: 4'd1};
    table_rows.insert(table_rows.size(), row);
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random stall bursts, none in the last part of the run.
  always @(posedge clk) begin
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 9) == 0) begin
      out_stall <= $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    mip_result_t got, exp_r;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_level, out_col, out_row, out_rgba, out_last_of_item,
              out_pyramid_done, out_level_count};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction: %p", got);
      end else begin
        exp_r = pending_results[0];
        pending_results.delete(0);
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("Result mismatch: expected %p, got %p", exp_r, got);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int total, w, h, npix, full;
    mip_result_t none;
    none = '0;
    rst_n <= 1'b0; cfg_we <= 1'b0; cfg_addr <= '0; cfg_wdata <= '0;
    in_valid <= 1'b0; in_pixel_rgba <= '0;
    img_w = 1; img_h = 1;
    for (int i = 0; i < RB_DEPTH; i++) pair_rows[i] = '0;
    for (int i = 0; i < MAX_LEVELS; i++) left_pix[i] = '0;
    rebuild_levels();

    // Directed table: reset size, clamped sizes, a 2x2 and an odd 3x3 image.
    add_row(0, 0, 0, 32'h0000_0000, 1);
    add_row(0, 0, 0, 32'hFFFF_FFFF, 1);
    add_row(0, 0, 0, 32'hA5C3_5A3C, 1);
    add_row(1, CFG_IMAGE_WIDTH, 13'd0, 0, 0);
    add_row(1, CFG_IMAGE_HEIGHT, 13'h1FFF, 0, 0);
    add_row(0, 0, 0, 32'hFFFF_FFFF, 0);
    add_row(0, 0, 0, 32'h0000_0001, 0);
    add_row(0, 0, 0, 32'h8080_8080, 0);
    add_row(1, CFG_IMAGE_WIDTH, 13'd2, 0, 0);
    add_row(1, CFG_IMAGE_HEIGHT, 13'd2, 0, 0);
    add_row(0, 0, 0, 32'hFFFF_FFFF, 0);
    add_row(0, 0, 0, 32'hFFFF_FFFF, 0);
    add_row(0, 0, 0, 32'hFFFF_FFFF, 0);
    add_row(0, 0, 0, 32'h0000_0000, 0);
    add_row(0, 0, 0, 32'h0102_0304, 0);
    add_row(1, CFG_IMAGE_WIDTH, 13'd3, 0, 0);
    add_row(1, CFG_IMAGE_HEIGHT, 13'd3, 0, 0);
    for (int i = 0; i < 9; i++) add_row(0, 0, 0, 32'h1111_1111 * i, 0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (table_rows[i]) begin
      if (table_rows[i].is_cfg) cfg_write(table_rows[i].addr, table_rows[i].data);
      else send_pixel(table_rows[i].pix, table_rows[i].typed, table_rows[i].want);
    end

    // Extreme sizes: the start of a widest row, of a tallest column and of a
    // largest image.
    cfg_write(CFG_IMAGE_WIDTH, 13'd4096);
    cfg_write(CFG_IMAGE_HEIGHT, 13'd1);
    repeat (100) send_pixel(rand_pixel(), 0, none);
    cfg_write(CFG_IMAGE_WIDTH, 13'd1);
    cfg_write(CFG_IMAGE_HEIGHT, 13'd4096);
    repeat (100) send_pixel(rand_pixel(), 0, none);
    cfg_write(CFG_IMAGE_HEIGHT, 13'd4096);
    cfg_write(CFG_IMAGE_WIDTH, 13'd4096);
    repeat (50) send_pixel(rand_pixel(), 0, none);

    // Random phases: mostly whole images, some cut short, some with spare pixels.
    total = 0;
    while (total < 250) begin
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 9);
      h = $urandom_range(1, 9);
      cfg_write(CFG_IMAGE_WIDTH, w[DIM_W-1:0]);
      cfg_write(CFG_IMAGE_HEIGHT, h[DIM_W-1:0]);
      full = w * h;
      case ($urandom_range(0, 5))
        0: npix = $urandom_range(1, full);
        1: npix = full + $urandom_range(1, full);
        default: npix = full;
      endcase
      if (total > 180) no_idle = 1;
      for (int i = 0; i < npix; i++) begin
        send_pixel(rand_pixel(), 0, none);
        // Once, hold the sender until every queued result has drained.
        if (!drained_once && total >= 60 && i == npix / 2) begin
          drained_once = 1;
          in_valid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
      end
      total += npix;
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* box_filter_mip_chain_unit.f */
design/bfm_pkg.sv
design/bfm_ram.sv
design/bfm_fifo.sv
design/bfm_front.sv
design/bfm_back.sv
design/box_filter_mip_chain_unit.sv
bench/tb_box_filter_mip_chain_unit.sv
